// ===== rtl/i2f_pkg.sv =====
// i2f_pkg: shared constants for the integer to floating-point converter
// no dependencies; used by every module under rtl

package i2f_pkg;

    // command codes
    localparam logic CMD_INT    = 1'b0;
    localparam logic CMD_DOUBLE = 1'b1;

    // float_format register codes
    localparam logic FMT_IEEE = 1'b0;
    localparam logic FMT_DEC  = 1'b1;

    // field widths and biases
    localparam int INT_W        = 32;
    localparam int DBL_W        = 64;
    localparam int IEEE_EXP_W   = 11;
    localparam int IEEE_MANT_W  = 52;
    localparam int DEC_EXP_W    = 8;
    localparam int DEC_MANT_W   = 55;
    localparam int SGL_EXP_W    = 8;
    localparam int SGL_MANT_W   = 23;
    localparam int LZ_W         = 5;

    localparam logic [IEEE_EXP_W-1:0] IEEE_BIAS = 11'd1023;
    localparam logic [DEC_EXP_W-1:0]  DEC_BIAS  = 8'd128;
    localparam logic [SGL_EXP_W-1:0]  SGL_BIAS  = 8'd127;

    // ieee double exponent minus single exponent bias difference (1023 - 127)
    localparam logic [IEEE_EXP_W:0] REBIAS = 12'd896;

endpackage

// ===== rtl/i2f_norm.sv =====
// i2f_norm: exact conversion of a signed 32-bit integer to a double pattern
// leading-zero normalize in five halving steps; depends on i2f_pkg

module i2f_norm (
    input  logic signed [i2f_pkg::INT_W-1:0] i_int_value,
    input  logic                             i_dec,
    output logic        [i2f_pkg::DBL_W-1:0] o_bits
);

    logic [i2f_pkg::INT_W-1:0]      mag;
    logic [i2f_pkg::INT_W-1:0]      norm;
    logic [i2f_pkg::LZ_W-1:0]       lz;
    logic [i2f_pkg::LZ_W-1:0]       top;
    logic                           sign;
    logic [i2f_pkg::IEEE_EXP_W-1:0] ieee_exp;
    logic [i2f_pkg::DEC_EXP_W-1:0]  dec_exp;

    assign sign = i_int_value[i2f_pkg::INT_W-1];
    assign mag  = sign ? (~i_int_value + 32'd1) : i_int_value;

    // halving search: shift left until the top bit is set
    always_comb begin
        norm = mag;
        lz   = '0;
        for (int k = i2f_pkg::LZ_W - 1; k >= 0; k--) begin
            if ((norm >> (i2f_pkg::INT_W - (1 << k))) == '0) begin
                norm  = norm << (1 << k);
                lz[k] = 1'b1;
            end
        end
    end

    assign top      = 5'd31 - lz;
    assign ieee_exp = i2f_pkg::IEEE_BIAS + {6'b0, top};
    assign dec_exp  = i2f_pkg::DEC_BIAS + 8'd1 + {3'b0, top};

    always_comb begin
        if (mag == '0) begin
            o_bits = '0;
        end else if (i_dec) begin
            o_bits = {sign, dec_exp, norm[30:0], 24'b0};
        end else begin
            o_bits = {sign, ieee_exp, norm[30:0], 21'b0};
        end
    end

endmodule

// ===== rtl/i2f_narrow.sv =====
// i2f_narrow: optional narrowing of a double pattern to single precision
// ieee rebias with truncation and range flag, dec keeps upper word; uses i2f_pkg

module i2f_narrow (
    input  logic [i2f_pkg::DBL_W-1:0] i_bits,
    input  logic                      i_dec,
    input  logic                      i_to_single,
    output logic [i2f_pkg::DBL_W-1:0] o_bits,
    output logic                      o_range_flag
);

    logic [i2f_pkg::IEEE_EXP_W-1:0] exp_d;
    logic [i2f_pkg::IEEE_EXP_W:0]   exp_s;

    assign exp_d = i_bits[62:52];
    // 12-bit two's complement; zero exponent is not rebiased
    assign exp_s = (exp_d == '0) ? '0 : ({1'b0, exp_d} - i2f_pkg::REBIAS);

    always_comb begin
        o_bits       = i_bits;
        o_range_flag = 1'b0;
        if (i_to_single) begin
            if (i_dec) begin
                o_bits = {32'b0, i_bits[63:32]};
            end else begin
                o_bits       = {32'b0, i_bits[63], exp_s[7:0], i_bits[51:29]};
                o_range_flag = |exp_s[11:8];
            end
        end
    end

endmodule

// ===== rtl/int_to_float_converter.sv =====
// int_to_float_converter: integer or double constant to ieee / dec float pattern
// start passes through r_in_vld and r_out_vld to o_result_valid, throughput one item per cycle
// busy stays low: the receiver cannot stall and nothing is held back
// i_rst_n is synchronous, active low; clears the valid pipeline and float_format
// float_format resets to ieee layout; depends on i2f_pkg, i2f_norm, i2f_narrow

module int_to_float_converter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item input
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_command,
    input  logic signed [i2f_pkg::INT_W-1:0] i_int_value,
    input  logic        [i2f_pkg::DBL_W-1:0] i_double_bits,
    input  logic                             i_to_single,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_data,
    // result
    output logic                             o_result_valid,
    output logic        [i2f_pkg::DBL_W-1:0] o_result_bits,
    output logic                             o_range_flag
);

    // configuration register
    logic r_float_format;

    // input stage
    logic                             r_in_vld;
    logic                             r_command;
    logic signed [i2f_pkg::INT_W-1:0] r_int_value;
    logic        [i2f_pkg::DBL_W-1:0] r_double_bits;
    logic                             r_to_single;

    // result stage
    logic                      r_out_vld;
    logic [i2f_pkg::DBL_W-1:0] r_result_bits;
    logic                      r_range_flag;

    logic                      dec;
    logic                      accept;
    logic [i2f_pkg::DBL_W-1:0] int_bits;
    logic [i2f_pkg::DBL_W-1:0] dbl_bits;
    logic [i2f_pkg::DBL_W-1:0] n_result_bits;
    logic                      n_range_flag;

    // fully pipelined, so items are always taken
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start & ~busy;
    assign dec         = (r_float_format == i2f_pkg::FMT_DEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_float_format <= i2f_pkg::FMT_IEEE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_float_format <= i_cfg_data;
        end
    end

    // input register: control reset, payload free running on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_command     <= i_command;
            r_int_value   <= i_int_value;
            r_double_bits <= i_double_bits;
            r_to_single   <= i_to_single;
        end
    end

    // integer normalize: leading-zero search and shift
    i2f_norm u_norm (
        .i_int_value (r_int_value),
        .i_dec       (dec),
        .o_bits      (int_bits)
    );

    // pick the double source by command
    assign dbl_bits = (r_command == i2f_pkg::CMD_DOUBLE) ? r_double_bits : int_bits;

    // optional narrowing to single
    i2f_narrow u_narrow (
        .i_bits       (dbl_bits),
        .i_dec        (dec),
        .i_to_single  (r_to_single),
        .o_bits       (n_result_bits),
        .o_range_flag (n_range_flag)
    );

    // result register: one strobe cycle per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_result_bits <= n_result_bits;
            r_range_flag  <= n_range_flag;
        end
    end

    assign o_result_valid = r_out_vld;
    assign o_result_bits  = r_result_bits;
    assign o_range_flag   = r_range_flag;

endmodule
